// ----- hdl/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants for the music playlist sequencer.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int MAX_NODES  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_NODES);
    localparam int LEN_BITS   = 5;
    localparam int CLOCK_BITS = 25;
    localparam int TICK_BITS  = 16;
    localparam int KEY_BITS   = 16;
    localparam int PLAY_BITS  = 24;
    localparam int FADE_BITS  = 16;

    localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(MAX_NODES);

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_LOAD   = 3'd1,
        CMD_PLAY   = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_PAUSE  = 3'd4,
        CMD_RESUME = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_START      = 3'd1,
        ACT_START_FADE = 3'd2,
        ACT_HALT       = 3'd3,
        ACT_FADE_OUT   = 3'd4,
        ACT_PAUSE      = 3'd5,
        ACT_RESUME     = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PAUSED  = 2'd1,
        MODE_PLAYING = 2'd2,
        MODE_FADING  = 2'd3
    } mode_t;

endpackage

// ----- hdl/music_playlist_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// music_playlist_sequencer_core
// Steps through a table of music nodes on tick, load, play, stop, pause and
// resume requests, and reports one action per request.
// ----------------------------------------------------------------------------
// Every request yields exactly one result. A request is taken into an input
// register, evaluated against the player state and the node table, and the
// result lands in an output register, so one request per cycle is sustained.
// Only a stalled result register (m_ready low) holds off new requests. The
// node table holds 16 slots of key, play time, fade-in and fade-out time; a
// slot that was never loaded reads back an unspecified value.
module music_playlist_sequencer_core
    import mps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_command,
    input  logic [TICK_BITS-1:0]  s_tick_ms,
    input  logic [SLOT_BITS-1:0]  s_node_index,
    input  logic [KEY_BITS-1:0]   s_node_key,
    input  logic [PLAY_BITS-1:0]  s_node_play_ms,
    input  logic [FADE_BITS-1:0]  s_node_fade_in_ms,
    input  logic [FADE_BITS-1:0]  s_node_fade_out_ms,
    input  logic [LEN_BITS-1:0]   s_sequence_length,
    input  logic                  s_loop_flag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_action,
    output logic [KEY_BITS-1:0]   m_music_key,
    output logic [FADE_BITS-1:0]  m_fade_ms,
    output logic [1:0]            m_player_state,
    output logic [SLOT_BITS-1:0]  m_node_position
);

    // input register
    logic                  in_valid_reg;
    cmd_t                  cmd_reg;
    logic [TICK_BITS-1:0]  tick_reg;
    logic [SLOT_BITS-1:0]  index_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [PLAY_BITS-1:0]  play_reg;
    logic [FADE_BITS-1:0]  fade_in_reg;
    logic [FADE_BITS-1:0]  fade_out_reg;
    logic [LEN_BITS-1:0]   len_reg;
    logic                  loop_reg;

    // player state
    mode_t                 mode_reg, mode_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic [CLOCK_BITS-1:0] clock_reg, clock_next;
    logic                  looping_reg, looping_next;
    logic [LEN_BITS-1:0]   used_len_reg, used_len_next;

    // node table
    logic [KEY_BITS-1:0]   slot_keys     [MAX_NODES];
    logic [PLAY_BITS-1:0]  slot_play     [MAX_NODES];
    logic [FADE_BITS-1:0]  slot_fade_in  [MAX_NODES];
    logic [FADE_BITS-1:0]  slot_fade_out [MAX_NODES];

    // result register
    logic                  out_valid_reg;
    action_t               action_reg, action_next;
    logic [KEY_BITS-1:0]   key_out_reg, key_out_next;
    logic [FADE_BITS-1:0]  fade_ms_reg, fade_ms_next;

    logic                  advance;
    logic [CLOCK_BITS:0]   clock_sum;
    logic [CLOCK_BITS-1:0] clock_adv;
    logic [PLAY_BITS-1:0]  cur_play;
    logic [FADE_BITS-1:0]  cur_fade_out;
    logic                  play_end;
    logic                  fade_end;
    logic [SLOT_BITS:0]    slot_inc;
    logic                  at_last;
    logic                  wrap;
    logic [SLOT_BITS-1:0]  start_slot;
    logic [KEY_BITS-1:0]   start_key;
    logic [FADE_BITS-1:0]  start_fade_in;
    logic [LEN_BITS-1:0]   len_clamped;
    logic                  is_tick;
    logic                  next_node;
    logic                  ends_list;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg      <= cmd_t'(s_command);
            tick_reg     <= s_tick_ms;
            index_reg    <= s_node_index;
            key_reg      <= s_node_key;
            play_reg     <= s_node_play_ms;
            fade_in_reg  <= s_node_fade_in_ms;
            fade_out_reg <= s_node_fade_out_ms;
            len_reg      <= s_sequence_length;
            loop_reg     <= s_loop_flag;
        end
    end

    // current node lookup and clock advance
    assign cur_play     = slot_play[slot_reg];
    assign cur_fade_out = slot_fade_out[slot_reg];
    assign clock_sum    = {1'b0, clock_reg} + (CLOCK_BITS+1)'(tick_reg);
    assign clock_adv    = clock_sum[CLOCK_BITS] ? {CLOCK_BITS{1'b1}}
                                                : clock_sum[CLOCK_BITS-1:0];

    // clock > play - fade_out, kept unsigned by moving fade_out across
    assign play_end = ((CLOCK_BITS+1)'(clock_adv) + (CLOCK_BITS+1)'(cur_fade_out))
                      > (CLOCK_BITS+1)'(cur_play);
    assign fade_end = clock_adv > CLOCK_BITS'(cur_fade_out);

    assign slot_inc = {1'b0, slot_reg} + (SLOT_BITS+1)'(1);
    assign at_last  = LEN_BITS'(slot_inc) >= used_len_reg;
    assign wrap     = at_last && looping_reg;

    assign is_tick   = (cmd_reg == CMD_TICK);
    assign next_node = is_tick && (mode_reg == MODE_FADING) && fade_end;
    assign ends_list = next_node && at_last && !looping_reg;

    // play and wrap start at slot zero; otherwise start the following slot
    assign start_slot    = (cmd_reg == CMD_PLAY || wrap) ? '0 : slot_inc[SLOT_BITS-1:0];
    assign start_key     = slot_keys[start_slot];
    assign start_fade_in = slot_fade_in[start_slot];

    assign len_clamped = (len_reg > LEN_LIMIT) ? LEN_LIMIT : len_reg;

    // next state
    always_comb begin
        mode_next     = mode_reg;
        slot_next     = slot_reg;
        clock_next    = clock_reg;
        looping_next  = looping_reg;
        used_len_next = used_len_reg;
        unique case (cmd_reg)
            CMD_TICK: begin
                if (mode_reg == MODE_PLAYING) begin
                    clock_next = clock_adv;
                    if (play_end) begin
                        mode_next  = MODE_FADING;
                        clock_next = '0;
                    end
                end else if (mode_reg == MODE_FADING) begin
                    clock_next = clock_adv;
                    if (fade_end) begin
                        clock_next = '0;
                        if (ends_list) begin
                            mode_next     = MODE_STOPPED;
                            slot_next     = '0;
                            used_len_next = '0;
                        end else begin
                            mode_next = MODE_PLAYING;
                            slot_next = start_slot;
                        end
                    end
                end
            end
            CMD_PLAY: begin
                slot_next     = '0;
                clock_next    = '0;
                looping_next  = loop_reg;
                used_len_next = len_clamped;
                mode_next     = (len_clamped == '0) ? MODE_STOPPED : MODE_PLAYING;
            end
            CMD_STOP: begin
                if (mode_reg != MODE_STOPPED) begin
                    mode_next     = MODE_STOPPED;
                    slot_next     = '0;
                    clock_next    = '0;
                    used_len_next = '0;
                end
            end
            CMD_PAUSE: begin
                if (mode_reg == MODE_PLAYING) begin
                    mode_next = MODE_PAUSED;
                end
            end
            CMD_RESUME: begin
                if (mode_reg == MODE_PAUSED) begin
                    mode_next = MODE_PLAYING;
                end
            end
            default: begin
            end
        endcase
    end

    // result action
    always_comb begin
        action_next  = ACT_NONE;
        key_out_next = '0;
        fade_ms_next = '0;
        unique case (cmd_reg)
            CMD_TICK: begin
                if (mode_reg == MODE_PLAYING && play_end) begin
                    if (cur_fade_out != '0) begin
                        action_next  = ACT_FADE_OUT;
                        fade_ms_next = cur_fade_out;
                    end else begin
                        action_next = ACT_HALT;
                    end
                end else if (ends_list) begin
                    action_next = ACT_HALT;
                end else if (next_node) begin
                    key_out_next = start_key;
                    if (start_fade_in != '0) begin
                        action_next  = ACT_START_FADE;
                        fade_ms_next = start_fade_in;
                    end else begin
                        action_next = ACT_START;
                    end
                end
            end
            CMD_PLAY: begin
                if (len_clamped != '0) begin
                    key_out_next = start_key;
                    if (start_fade_in != '0) begin
                        action_next  = ACT_START_FADE;
                        fade_ms_next = start_fade_in;
                    end else begin
                        action_next = ACT_START;
                    end
                end else if (mode_reg != MODE_STOPPED) begin
                    action_next = ACT_HALT;
                end
            end
            CMD_STOP: begin
                if (mode_reg != MODE_STOPPED) begin
                    action_next = ACT_HALT;
                end
            end
            CMD_PAUSE: begin
                if (mode_reg == MODE_PLAYING) begin
                    action_next = ACT_PAUSE;
                end
            end
            CMD_RESUME: begin
                if (mode_reg == MODE_PAUSED) begin
                    action_next = ACT_RESUME;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_STOPPED;
            slot_reg      <= '0;
            clock_reg     <= '0;
            looping_reg   <= 1'b0;
            used_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg     <= mode_next;
                slot_reg     <= slot_next;
                clock_reg    <= clock_next;
                looping_reg  <= looping_next;
                used_len_reg <= used_len_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            action_reg  <= action_next;
            key_out_reg <= key_out_next;
            fade_ms_reg <= fade_ms_next;
        end
    end

    // table is live: a load lands before the next request reads it
    always_ff @(posedge aclk) begin
        if (advance && cmd_reg == CMD_LOAD) begin
            slot_keys[index_reg]     <= key_reg;
            slot_play[index_reg]     <= play_reg;
            slot_fade_in[index_reg]  <= fade_in_reg;
            slot_fade_out[index_reg] <= fade_out_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_action        = action_reg;
    assign m_music_key     = key_out_reg;
    assign m_fade_ms       = fade_ms_reg;
    assign m_player_state  = mode_reg;
    assign m_node_position = slot_reg;

endmodule

// ----- test/mps_checker.sv -----
// ----------------------------------------------------------------------------
// mps_checker
// Watches both channels of the playlist sequencer. It runs its own copy of
// the player on every accepted request, queues the report that the request
// should produce, and compares each returned report field by field.
// ----------------------------------------------------------------------------
module mps_checker
    import mps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [2:0]            s_command,
    input  logic [TICK_BITS-1:0]  s_tick_ms,
    input  logic [SLOT_BITS-1:0]  s_node_index,
    input  logic [KEY_BITS-1:0]   s_node_key,
    input  logic [PLAY_BITS-1:0]  s_node_play_ms,
    input  logic [FADE_BITS-1:0]  s_node_fade_in_ms,
    input  logic [FADE_BITS-1:0]  s_node_fade_out_ms,
    input  logic [LEN_BITS-1:0]   s_sequence_length,
    input  logic                  s_loop_flag,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [2:0]            m_action,
    input  logic [KEY_BITS-1:0]   m_music_key,
    input  logic [FADE_BITS-1:0]  m_fade_ms,
    input  logic [1:0]            m_player_state,
    input  logic [SLOT_BITS-1:0]  m_node_position,
    output int                    fail_count,
    output int                    pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = '1;

    typedef struct packed {
        logic [2:0]           action;
        logic [KEY_BITS-1:0]  key;
        logic [FADE_BITS-1:0] fade;
        logic [1:0]           state;
        logic [SLOT_BITS-1:0] position;
    } player_report_t;

    // player copy
    mode_t                 play_state;
    logic [SLOT_BITS-1:0]  cur_node;
    logic [CLOCK_BITS-1:0] elapsed_ms;
    logic                  wrap_on;
    logic [LEN_BITS-1:0]   list_len;
    logic [KEY_BITS-1:0]   key_tab     [MAX_NODES];
    logic [PLAY_BITS-1:0]  play_tab    [MAX_NODES];
    logic [FADE_BITS-1:0]  fade_in_tab [MAX_NODES];
    logic [FADE_BITS-1:0]  fade_out_tab[MAX_NODES];

    action_t               act;
    logic [KEY_BITS-1:0]   act_key;
    logic [FADE_BITS-1:0]  act_fade;

    player_report_t        due_reports[$];
    int                    fails;

    function automatic void halt_all();
        if (play_state != MODE_STOPPED) begin
            elapsed_ms = '0;
            cur_node   = '0;
            play_state = MODE_STOPPED;
            list_len   = '0;
            act        = ACT_HALT;
        end
    endfunction

    function automatic void advance_clock(logic [TICK_BITS-1:0] dt);
        logic [CLOCK_BITS:0] sum;
        sum = (CLOCK_BITS+1)'(elapsed_ms) + (CLOCK_BITS+1)'(dt);
        elapsed_ms = (sum > (CLOCK_BITS+1)'(CLOCK_MAX)) ? CLOCK_MAX : sum[CLOCK_BITS-1:0];
    endfunction

    function automatic void launch_node();
        act_key = key_tab[cur_node];
        if (fade_in_tab[cur_node] != '0) begin
            act      = ACT_START_FADE;
            act_fade = fade_in_tab[cur_node];
        end else begin
            act = ACT_START;
        end
        play_state = MODE_PLAYING;
    endfunction

    function automatic player_report_t step_player();
        logic [LEN_BITS-1:0] next_node;
        logic [LEN_BITS-1:0] span;
        player_report_t      rep;
        act      = ACT_NONE;
        act_key  = '0;
        act_fade = '0;
        case (s_command)
            CMD_TICK: begin
                if (play_state == MODE_PLAYING) begin
                    advance_clock(s_tick_ms);
                    // clock > play - fade_out, kept unsigned
                    if (32'(elapsed_ms) + 32'(fade_out_tab[cur_node])
                            > 32'(play_tab[cur_node])) begin
                        if (fade_out_tab[cur_node] != '0) begin
                            act      = ACT_FADE_OUT;
                            act_fade = fade_out_tab[cur_node];
                        end else begin
                            act = ACT_HALT;
                        end
                        play_state = MODE_FADING;
                        elapsed_ms = '0;
                    end
                end else if (play_state == MODE_FADING) begin
                    advance_clock(s_tick_ms);
                    if (32'(elapsed_ms) > 32'(fade_out_tab[cur_node])) begin
                        next_node = LEN_BITS'(cur_node) + 5'd1;
                        if (next_node >= list_len && !wrap_on) begin
                            halt_all();
                        end else begin
                            if (next_node >= list_len)
                                next_node = '0;
                            cur_node = next_node[SLOT_BITS-1:0];
                            launch_node();
                            elapsed_ms = '0;
                        end
                    end
                end
            end
            CMD_LOAD: begin
                key_tab[s_node_index]      = s_node_key;
                play_tab[s_node_index]     = s_node_play_ms;
                fade_in_tab[s_node_index]  = s_node_fade_in_ms;
                fade_out_tab[s_node_index] = s_node_fade_out_ms;
            end
            CMD_PLAY: begin
                span = (s_sequence_length > LEN_LIMIT) ? LEN_LIMIT : s_sequence_length;
                halt_all();
                cur_node   = '0;
                elapsed_ms = '0;
                wrap_on    = s_loop_flag;
                list_len   = span;
                if (span == '0)
                    play_state = MODE_STOPPED;
                else
                    launch_node();
            end
            CMD_STOP: begin
                halt_all();
            end
            CMD_PAUSE: begin
                if (play_state == MODE_PLAYING) begin
                    play_state = MODE_PAUSED;
                    act        = ACT_PAUSE;
                end
            end
            CMD_RESUME: begin
                if (play_state == MODE_PAUSED) begin
                    play_state = MODE_PLAYING;
                    act        = ACT_RESUME;
                end
            end
            default: ;
        endcase
        rep.action   = act;
        rep.key      = act_key;
        rep.fade     = act_fade;
        rep.state    = play_state;
        rep.position = cur_node;
        return rep;
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        player_report_t want;
        if (!aresetn) begin
            play_state = MODE_STOPPED;
            cur_node   = '0;
            elapsed_ms = '0;
            wrap_on    = 1'b0;
            list_len   = '0;
            due_reports.delete();
        end else begin
            if (s_valid && s_ready)
                due_reports.insert(due_reports.size(), step_player());
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    $error("report returned with no request outstanding");
                    fails++;
                end else begin
                    want = due_reports.pop_front();
                    compare_field("action", 32'(want.action), 32'(m_action));
                    compare_field("music_key", 32'(want.key), 32'(m_music_key));
                    compare_field("fade_ms", 32'(want.fade), 32'(m_fade_ms));
                    compare_field("player_state", 32'(want.state), 32'(m_player_state));
                    compare_field("node_position", 32'(want.position),
                                  32'(m_node_position));
                end
            end
        end
        pending_results <= due_reports.size();
        fail_count      <= fails;
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the playlist sequencer with directed and random requests: loads,
// playlists with ticks, pause, resume, stop and unused codes, with random
// gaps on both channels and one long result stall. The checker predicts
// and compares every report; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import mps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1200;
    localparam int CALM_TAIL   = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 64;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [2:0]            s_command;
    logic [TICK_BITS-1:0]  s_tick_ms;
    logic [SLOT_BITS-1:0]  s_node_index;
    logic [KEY_BITS-1:0]   s_node_key;
    logic [PLAY_BITS-1:0]  s_node_play_ms;
    logic [FADE_BITS-1:0]  s_node_fade_in_ms;
    logic [FADE_BITS-1:0]  s_node_fade_out_ms;
    logic [LEN_BITS-1:0]   s_sequence_length;
    logic                  s_loop_flag;
    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_action;
    logic [KEY_BITS-1:0]   m_music_key;
    logic [FADE_BITS-1:0]  m_fade_ms;
    logic [1:0]            m_player_state;
    logic [SLOT_BITS-1:0]  m_node_position;
    int                    fail_count;
    int                    pending_results;

    int sent;
    bit calm;
    bit long_hold_done;

    music_playlist_sequencer_core u_top (.*);

    mps_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic offer(input logic [2:0] cmd, input logic [TICK_BITS-1:0] dt,
                         input logic [SLOT_BITS-1:0] idx, input logic [KEY_BITS-1:0] key,
                         input logic [PLAY_BITS-1:0] play, input logic [FADE_BITS-1:0] fin,
                         input logic [FADE_BITS-1:0] fout, input logic [LEN_BITS-1:0] len,
                         input logic loop);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_command          <= cmd;
        s_tick_ms          <= dt;
        s_node_index       <= idx;
        s_node_key         <= key;
        s_node_play_ms     <= play;
        s_node_fade_in_ms  <= fin;
        s_node_fade_out_ms <= fout;
        s_sequence_length  <= len;
        s_loop_flag        <= loop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (sent >= ITEM_TARGET - CALM_TAIL)
            calm = 1'b1;
    endtask

    // unused fields carry noise
    task automatic bare_req(input logic [2:0] cmd);
        offer(cmd, TICK_BITS'($urandom), SLOT_BITS'($urandom), KEY_BITS'($urandom),
              PLAY_BITS'($urandom), FADE_BITS'($urandom), FADE_BITS'($urandom),
              LEN_BITS'($urandom), 1'($urandom));
    endtask

    task automatic tick_req(input logic [TICK_BITS-1:0] dt);
        offer(CMD_TICK, dt, SLOT_BITS'($urandom), KEY_BITS'($urandom),
              PLAY_BITS'($urandom), FADE_BITS'($urandom), FADE_BITS'($urandom),
              LEN_BITS'($urandom), 1'($urandom));
    endtask

    task automatic load_req(input logic [SLOT_BITS-1:0] idx, input logic [KEY_BITS-1:0] key,
                            input logic [PLAY_BITS-1:0] play,
                            input logic [FADE_BITS-1:0] fin, input logic [FADE_BITS-1:0] fout);
        offer(CMD_LOAD, TICK_BITS'($urandom), idx, key, play, fin, fout,
              LEN_BITS'($urandom), 1'($urandom));
    endtask

    task automatic play_req(input logic [LEN_BITS-1:0] len, input logic loop);
        offer(CMD_PLAY, TICK_BITS'($urandom), SLOT_BITS'($urandom), KEY_BITS'($urandom),
              PLAY_BITS'($urandom), FADE_BITS'($urandom), FADE_BITS'($urandom),
              len, loop);
    endtask

    // mostly short nodes so playlists actually advance; now and then a huge one
    task automatic load_random(input logic [SLOT_BITS-1:0] idx);
        logic [PLAY_BITS-1:0] play;
        logic [FADE_BITS-1:0] fin;
        logic [FADE_BITS-1:0] fout;
        play = ($urandom_range(0, 19) == 0) ? PLAY_BITS'($urandom)
                                            : PLAY_BITS'($urandom_range(0, 3000));
        fin  = ($urandom_range(0, 3) == 0) ? '0 : FADE_BITS'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: fout = '0;
            3:       fout = FADE_BITS'($urandom);
            default: fout = FADE_BITS'($urandom_range(1, 800));
        endcase
        load_req(idx, KEY_BITS'($urandom), play, fin, fout);
    endtask

    // receiver: random stalls, one long hold-off, none in the tail
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (calm) begin
                m_ready <= 1'b1;
            end else if (!long_hold_done && sent >= HOLD_AT) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_command          = CMD_TICK;
        s_tick_ms          = '0;
        s_node_index       = '0;
        s_node_key         = '0;
        s_node_play_ms     = '0;
        s_node_fade_in_ms  = '0;
        s_node_fade_out_ms = '0;
        s_sequence_length  = '0;
        s_loop_flag        = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // idle player: nothing to stop, resume or start
        bare_req(CMD_STOP);
        bare_req(CMD_RESUME);
        play_req(5'd0, 1'b1);
        bare_req(CMD_SPARE_LO);
        bare_req(CMD_SPARE_HI);

        // fill the table before anything reads it
        load_req(4'd0, 16'hFFFF, 24'd0, 16'hFFFF, 16'hFFFF);
        load_req(4'd1, 16'h0000, 24'hFFFFFF, 16'h0000, 16'h0000);
        for (int i = 2; i < MAX_NODES; i++)
            load_req(SLOT_BITS'(i), KEY_BITS'($urandom), PLAY_BITS'(100 * i),
                     (i % 2 == 1) ? 16'd0 : 16'd20, (i % 3 == 0) ? 16'd0 : 16'd30);

        // fade-out longer than play time ends node 0 on the first tick
        play_req(5'd2, 1'b0);
        tick_req(16'd0);
        tick_req(16'hFFFF);
        tick_req(16'd1);
        bare_req(CMD_PAUSE);
        tick_req(16'd500);
        bare_req(CMD_RESUME);
        play_req(5'd31, 1'b1);
        bare_req(CMD_STOP);

        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 3)) load_random(SLOT_BITS'($urandom));
                play_req(($urandom_range(0, 15) == 0) ? LEN_BITS'($urandom)
                                                      : LEN_BITS'($urandom_range(1, 16)),
                         1'($urandom));
                repeat ($urandom_range(5, 40)) begin
                    case ($urandom_range(0, 29))
                        0, 1:    bare_req(CMD_PAUSE);
                        2, 3:    bare_req(CMD_RESUME);
                        4:       load_random(SLOT_BITS'($urandom));
                        5:       bare_req(CMD_STOP);
                        default: tick_req(TICK_BITS'($urandom_range(0, 700)));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 7))
                        0:       load_random(SLOT_BITS'($urandom));
                        1:       tick_req(TICK_BITS'($urandom));
                        default: bare_req(3'($urandom_range(CMD_PLAY, CMD_SPARE_HI)));
                    endcase
                end
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mps_pkg.sv
hdl/music_playlist_sequencer_core.sv
test/mps_checker.sv
test/tb_top.sv
